### rtl/linear_blend_skinning_core_macros.svh
// Assertion macros for the linear blend skinning core checker.
// No dependencies; included by the checker file only.
`ifndef LINEAR_BLEND_SKINNING_CORE_MACROS_SVH
`define LINEAR_BLEND_SKINNING_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lbsc_pkg.sv
// Shared types and constants for the linear blend skinning core.
// No dependencies; used by the core and its checker.
`default_nettype none

package lbsc_pkg;

    localparam int ELEM_W   = 32;   // Q16.16 element / coordinate width
    localparam int ACC_W    = 64;   // accumulator width
    localparam int WEIGHT_W = 17;
    localparam int IDX_W    = 6;    // load_joint / attach_index width
    localparam int ENTRY_W  = 4;
    localparam int LANES    = 4;    // elements per palette row
    localparam int ROW_W    = LANES * ELEM_W;

    // op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    // row numbers; the fourth code marks "no row left to read"
    localparam logic [1:0] ROW_X    = 2'd0;
    localparam logic [1:0] ROW_Y    = 2'd1;
    localparam logic [1:0] ROW_Z    = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;

    typedef struct packed {
        logic                       op;
        logic [IDX_W-1:0]           load_joint;
        logic [ENTRY_W-1:0]         load_entry;
        logic signed [ELEM_W-1:0]   load_value;
        logic signed [ELEM_W-1:0]   pos_x;
        logic signed [ELEM_W-1:0]   pos_y;
        logic signed [ELEM_W-1:0]   pos_z;
        logic [IDX_W-1:0]           attach_index;
        logic [WEIGHT_W-1:0]        weight;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0]   out_x;
        logic signed [ELEM_W-1:0]   out_y;
        logic signed [ELEM_W-1:0]   out_z;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/linear_blend_skinning_core.sv
// Linear blend skinning core: palette memory, shared row transform pipeline,
// weighted accumulators and output register. Depends on lbsc_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//
// A palette load writes the element straight into its lane of the row word
// and the next item is taken in the following cycle. A contribution makes
// three row reads through the single palette read port, then drains the
// product / row sum / weight / accumulate stages before the next item is
// accepted. An attachment outside the palette skips the reads. A last
// contribution waits in its final cycle while the output register still
// holds an untaken item. Reset (synchronous) clears control and
// accumulators only; the palette has no clearing pass and is undefined until
// loaded.
`default_nettype none

module linear_blend_skinning_core
    import lbsc_pkg::*;
#(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam int JW    = $clog2(MAX_JOINTS);  // joint index width
    localparam int AW    = JW + 2;              // palette address: {joint, row}
    localparam int DEPTH = MAX_JOINTS * LANES;  // row 3 of each joint unused
    localparam int WT_W  = WEIGHT_W + 1 + ELEM_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = -64'sh0000_0000_8000_0000;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Clamp to the 32-bit signed range.
    function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ELEM_W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[ELEM_W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[ELEM_W-1:0];
        end else begin
            r = x[ELEM_W-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- control
    t_state         r_state;
    logic [1:0]     r_iss_row;      // next row to read, ROW_NONE when done
    logic           r_v1, r_v2, r_v3, r_v4;
    logic           r_out_valid;
    t_out_item      r_out;

    // ------------------------------------------------------------- item regs
    logic signed [ELEM_W-1:0]   r_pos_x, r_pos_y, r_pos_z;
    logic [WEIGHT_W-1:0]        r_w;
    logic [JW-1:0]              r_e;
    logic                       r_last;

    // -------------------------------------------------------------- palette
    logic [ROW_W-1:0]           r_pal [DEPTH];
    logic [ROW_W-1:0]           r_rd_data;

    // ------------------------------------------------------------- datapath
    logic signed [ACC_W-1:0]    r_p0, r_p1, r_p2;
    logic signed [ELEM_W-1:0]   r_off;
    logic signed [ELEM_W-1:0]   r_t;
    logic signed [WT_W-1:0]     r_wt;
    logic [1:0]                 r_row1, r_row2, r_row3, r_row4;
    logic signed [ACC_W-1:0]    r_sum_x, r_sum_y, r_sum_z;

    logic                       w_in_acc;
    logic                       w_is_load;
    logic [IDX_W:0]             w_e7;
    logic                       w_hit;
    logic                       w_ld_ok;
    logic [AW-1:0]              w_wr_addr;
    logic [AW-1:0]              w_rd_addr;
    logic                       w_issue;
    logic                       w_done;
    logic                       w_out_free;
    logic                       w_emit;
    logic signed [ELEM_W-1:0]   w_m0, w_m1, w_m2, w_m3;
    logic signed [ACC_W-1:0]    w_s0, w_s1, w_s2, w_off64, w_tsum;
    logic signed [WT_W-1:0]     w_wt;
    logic signed [ACC_W-1:0]    w_wt64;
    logic signed [ACC_W-1:0]    w_shx, w_shy, w_shz;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_is_load  = (i_in_data.op == OP_LOAD);

    // palette entry attach_index+1, in range only below MAX_JOINTS
    assign w_e7  = {1'b0, i_in_data.attach_index} + (IDX_W+1)'(1);
    assign w_hit = (32'(w_e7) < 32'(MAX_JOINTS));

    // load target: entry row*4+col, rows 0..2 only
    assign w_ld_ok   = (32'(i_in_data.load_joint) < 32'(MAX_JOINTS))
                    && (i_in_data.load_entry[3:2] != ROW_NONE);
    assign w_wr_addr = {JW'(i_in_data.load_joint), i_in_data.load_entry[3:2]};
    assign w_rd_addr = {r_e, r_iss_row};

    assign w_issue    = (r_state == ST_RUN) && (r_iss_row != ROW_NONE);
    assign w_done     = (r_state == ST_RUN) && (r_iss_row == ROW_NONE)
                     && !(r_v1 || r_v2 || r_v3 || r_v4);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = w_done && r_last && w_out_free;

    // row lanes: m[r][0..3]
    assign w_m0 = $signed(r_rd_data[0*ELEM_W +: ELEM_W]);
    assign w_m1 = $signed(r_rd_data[1*ELEM_W +: ELEM_W]);
    assign w_m2 = $signed(r_rd_data[2*ELEM_W +: ELEM_W]);
    assign w_m3 = $signed(r_rd_data[3*ELEM_W +: ELEM_W]);

    // floor of each product by 2^FRAC_BITS, plus translation
    assign w_s0    = r_p0 >>> FRAC_BITS;
    assign w_s1    = r_p1 >>> FRAC_BITS;
    assign w_s2    = r_p2 >>> FRAC_BITS;
    assign w_off64 = {{(ACC_W-ELEM_W){r_off[ELEM_W-1]}}, r_off};
    assign w_tsum  = w_s0 + w_s1 + w_s2 + w_off64;

    // weight is unsigned; a zero top bit keeps it positive in the product
    assign w_wt   = WT_W'($signed({1'b0, r_w})) * WT_W'(r_t);
    assign w_wt64 = {{(ACC_W-WT_W){r_wt[WT_W-1]}}, r_wt};

    assign w_shx = r_sum_x >>> FRAC_BITS;
    assign w_shy = r_sum_y >>> FRAC_BITS;
    assign w_shz = r_sum_z >>> FRAC_BITS;

    // State machine, read sequencing and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iss_row   <= ROW_NONE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && !w_is_load) begin
                        r_state   <= ST_RUN;
                        r_iss_row <= w_hit ? ROW_X : ROW_NONE;
                    end
                end
                ST_RUN: begin
                    if (w_issue) begin
                        r_iss_row <= r_iss_row + 2'd1;
                    end
                    if (w_done && (!r_last || w_out_free)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_emit) begin
            r_out.out_x <= sat32(w_shx);
            r_out.out_y <= sat32(w_shy);
            r_out.out_z <= sat32(w_shz);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Palette: lane write on load, row read while sequencing.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_load && w_ld_ok) begin
            r_pal[w_wr_addr][{i_in_data.load_entry[1:0], 5'd0} +: ELEM_W]
                <= i_in_data.load_value;
        end
        if (w_issue) begin
            r_rd_data <= r_pal[w_rd_addr];
        end
    end

    // Item capture and the transform pipeline.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_is_load) begin
            r_pos_x <= i_in_data.pos_x;
            r_pos_y <= i_in_data.pos_y;
            r_pos_z <= i_in_data.pos_z;
            r_w     <= i_in_data.weight;
            r_e     <= JW'(w_e7);
            r_last  <= i_in_data.last;
        end

        r_row1 <= r_iss_row;
        r_row2 <= r_row1;
        r_row3 <= r_row2;
        r_row4 <= r_row3;

        // stage 2: three products of one row, 32 x 32 signed each
        r_p0  <= ACC_W'(w_m0) * ACC_W'(r_pos_x);
        r_p1  <= ACC_W'(w_m1) * ACC_W'(r_pos_y);
        r_p2  <= ACC_W'(w_m2) * ACC_W'(r_pos_z);
        r_off <= w_m3;
        // stage 3: row sum, saturated
        r_t   <= sat32(w_tsum);
        // stage 4: weighted row result
        r_wt  <= w_wt;
    end

    // Accumulators, wrapping modulo 2^64; cleared when a vertex is emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
        end else if (r_v4) begin
            unique case (r_row4)
                ROW_X:   r_sum_x <= r_sum_x + w_wt64;
                ROW_Y:   r_sum_y <= r_sum_y + w_wt64;
                ROW_Z:   r_sum_z <= r_sum_z + w_wt64;
                default: r_sum_x <= r_sum_x;
            endcase
        end else if (w_emit) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
        end
    end

endmodule

`default_nettype wire

### rtl/lbsc_checker.sv
// Port-level checker for the linear blend skinning core, bound to the top.
// Depends on lbsc_pkg and linear_blend_skinning_core_macros.svh.
`default_nettype none
`include "linear_blend_skinning_core_macros.svh"

module lbsc_checker
    import lbsc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    // stalled result item stays up
    `LBSC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "out valid dropped while stalled")
    // stalled result item keeps its payload
    `LBSC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data), "out item changed while stalled")
    // a palette load never creates a result item
    `LBSC_ASSERT_NEXT(a_load_quiet, w_in_acc && (i_in_data.op == OP_LOAD) && !o_out_valid, !o_out_valid, "result after a palette load")
    // an accepted contribution makes the core busy, with in ready low
    `LBSC_ASSERT_NEXT(a_blend_busy, w_in_acc && (i_in_data.op == OP_BLEND), !o_in_ready, "ready right after a contribution")

endmodule

bind linear_blend_skinning_core lbsc_checker u_lbsc_checker (.*);

`default_nettype wire
